FILE: src/crt_pkg.sv
// Shared constants and codes for the two-residue CRT codec.
// Used by the top level; the remainder pipeline takes no package items.
package crt_pkg;

	localparam int MODULUS_WIDTH = 17;

	localparam int P_RESET  = 104729;
	localparam int Q_RESET  = 104623;
	localparam int CX_RESET = 988;
	localparam int CY_RESET = -987;

	localparam int PLAIN_W     = 32;
	localparam int RAND_W      = 8;
	localparam int ENC_W       = 64;
	localparam int OUT_XY_W    = 26;
	localparam int DEC_W       = 34;
	localparam int IN_TDATA_W  = 176;
	localparam int OUT_TDATA_W = 88;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MODULUS_P  = 2'd0,
		CFG_MODULUS_Q  = 2'd1,
		CFG_COEF_FOR_X = 2'd2,
		CFG_COEF_FOR_Y = 2'd3
	} cfg_index_t;

	typedef enum logic {
		FUNC_ENCODE = 1'b0,
		FUNC_DECODE = 1'b1
	} func_t;

endpackage

FILE: src/crt_rem_pipe.sv
// Two-lane restoring remainder pipeline, one dividend bit per stage.
// Standalone module; instantiated twice by two_residue_crt_codec_top.
module crt_rem_pipe #(
	parameter int MW = 17,
	parameter int DW = 64,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_dvd_a,
	input  logic [DW-1:0] in_dvd_b,
	input  logic [MW-1:0] div_a,
	input  logic [MW-1:0] div_b,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [MW-1:0] out_rem_a,
	output logic [MW-1:0] out_rem_b,
	output logic [PW-1:0] out_pay
);

	function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] rem, input logic dbit,
			input logic [MW-1:0] dv);
		logic [MW:0] t;
		t = {rem, dbit};
		if (t >= {1'b0, dv}) begin
			t = t - {1'b0, dv};
		end
		return t[MW-1:0];
	endfunction

	logic          v_s     [DW];
	logic [MW-1:0] rem_a_s [DW];
	logic [MW-1:0] rem_b_s [DW];
	logic [DW-1:0] dvd_a_s [DW];
	logic [DW-1:0] dvd_b_s [DW];
	logic [PW-1:0] pay_s   [DW];
	logic [DW:0]   en;

	assign en[DW] = out_ready;
	assign in_ready = en[0];

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic          vin;
		logic [MW-1:0] ra_in;
		logic [MW-1:0] rb_in;
		logic [DW-1:0] da_in;
		logic [DW-1:0] db_in;
		logic [PW-1:0] pay_in;

		if (i == 0) begin : g_first
			assign vin    = in_valid;
			assign ra_in  = '0;
			assign rb_in  = '0;
			assign da_in  = in_dvd_a;
			assign db_in  = in_dvd_b;
			assign pay_in = in_pay;
		end else begin : g_next
			assign vin    = v_s[i-1];
			assign ra_in  = rem_a_s[i-1];
			assign rb_in  = rem_b_s[i-1];
			assign da_in  = dvd_a_s[i-1];
			assign db_in  = dvd_b_s[i-1];
			assign pay_in = pay_s[i-1];
		end

		assign en[i] = !v_s[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_a_s[i] <= rem_step(ra_in, da_in[DW-1], div_a);
				rem_b_s[i] <= rem_step(rb_in, db_in[DW-1], div_b);
				dvd_a_s[i] <= da_in << 1;
				dvd_b_s[i] <= db_in << 1;
				pay_s[i]   <= pay_in;
			end
		end
	end

	assign out_valid = v_s[DW-1];
	assign out_rem_a = rem_a_s[DW-1];
	assign out_rem_b = rem_b_s[DW-1];
	assign out_pay   = pay_s[DW-1];

endmodule

FILE: src/two_residue_crt_codec_top.sv
// Top level of the two-residue CRT codec: configuration, pipeline stages, fold.
// Depends on crt_pkg and crt_rem_pipe.
//
// channel   direction  handshake                     contents
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: func; tdata: operands
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: out_x, out_y, decoded_value
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One beat is accepted every cycle unless a stall on m_axis_tready backs the pipeline up to the input.
// Most of the depth lies in the two remainder pipelines: 64 stages for the operands and
// 2*MODULUS_WIDTH+2 stages for the stage-3 products, one bit per stage.
// Every stage holds its beat when the next one is full, so stalls lose nothing.
// Reset clears the valid bits and loads the default moduli and coefficients.
module two_residue_crt_codec_top #(
	parameter int MODULUS_WIDTH = crt_pkg::MODULUS_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// plain_value, rand_p, rand_q, enc_x, enc_y
	input  logic [crt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// func
	input  logic [0:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_x, out_y, decoded_value, two zero bits
	output logic [crt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [crt_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [MODULUS_WIDTH:0]            cfg_data
);

	localparam int MW  = MODULUS_WIDTH;
	localparam int EW  = crt_pkg::ENC_W;
	localparam int RW  = crt_pkg::RAND_W;
	localparam int XW  = crt_pkg::OUT_XY_W;
	localparam int DW2 = 2 * MW + 2;
	localparam int PW1 = 3 + 2 * RW;
	localparam int PW2 = 3 + 2 * XW;

	logic [MW-1:0]        p_q;
	logic [MW-1:0]        q_q;
	logic signed [MW:0]   cx_q;
	logic signed [MW:0]   cy_q;
	logic [2*MW-1:0]      m_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q  <= MW'(crt_pkg::P_RESET);
			q_q  <= MW'(crt_pkg::Q_RESET);
			cx_q <= (MW+1)'(crt_pkg::CX_RESET);
			cy_q <= (MW+1)'(crt_pkg::CY_RESET);
		end else if (cfg_valid) begin
			unique case (crt_pkg::cfg_index_t'(cfg_index))
				crt_pkg::CFG_MODULUS_P:  p_q  <= cfg_data[MW-1:0];
				crt_pkg::CFG_MODULUS_Q:  q_q  <= cfg_data[MW-1:0];
				crt_pkg::CFG_COEF_FOR_X: cx_q <= cfg_data;
				crt_pkg::CFG_COEF_FOR_Y: cy_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		m_q <= p_q * q_q;
	end

	// Stage enables.
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7, v8_s8, v9_s9;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9;
	logic p1_in_ready, p1_out_valid, p2_in_ready, p2_out_valid;

	assign en9 = !v9_s9 || m_axis_tready;
	assign en8 = !v8_s8 || en9;
	assign en7 = !v7_s7 || en8;
	assign en6 = !v6_s6 || en7;
	assign en5 = !v5_s5 || en6;
	assign en4 = !v4_s4 || p2_in_ready;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || p1_in_ready;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
			v7_s7 <= 1'b0;
			v8_s8 <= 1'b0;
			v9_s9 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= s_axis_tvalid;
			if (en2) v2_s2 <= p1_out_valid;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= p2_out_valid;
			if (en6) v6_s6 <= v5_s5;
			if (en7) v7_s7 <= v6_s6;
			if (en8) v8_s8 <= v7_s7;
			if (en9) v9_s9 <= v8_s8;
		end
	end

	// Stage 1: operand sign and magnitude.
	logic                 in_func;
	logic signed [EW-1:0] src_a, src_b;
	logic                 func_s1, neg_a_s1, neg_b_s1;
	logic [EW-1:0]        mag_a_s1, mag_b_s1;
	logic [RW-1:0]        rand_p_s1, rand_q_s1;

	assign in_func = s_axis_tuser[0];
	assign src_a = (in_func == crt_pkg::FUNC_DECODE) ? $signed(s_axis_tdata[111:48])
		: EW'($signed(s_axis_tdata[31:0]));
	assign src_b = (in_func == crt_pkg::FUNC_DECODE) ? $signed(s_axis_tdata[175:112])
		: EW'($signed(s_axis_tdata[31:0]));

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1   <= in_func;
			neg_a_s1  <= src_a[EW-1];
			neg_b_s1  <= src_b[EW-1];
			mag_a_s1  <= src_a[EW-1] ? EW'(-src_a) : EW'(src_a);
			mag_b_s1  <= src_b[EW-1] ? EW'(-src_b) : EW'(src_b);
			rand_p_s1 <= s_axis_tdata[39:32];
			rand_q_s1 <= s_axis_tdata[47:40];
		end
	end

	logic [MW-1:0]  r1_p, r1_q;
	logic [PW1-1:0] pay1_out;

	crt_rem_pipe #(.MW(MW), .DW(EW), .PW(PW1)) u_rem_operand (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1_s1),
		.in_ready  (p1_in_ready),
		.in_dvd_a  (mag_a_s1),
		.in_dvd_b  (mag_b_s1),
		.div_a     (p_q),
		.div_b     (q_q),
		.in_pay    ({func_s1, neg_a_s1, neg_b_s1, rand_p_s1, rand_q_s1}),
		.out_valid (p1_out_valid),
		.out_ready (en2),
		.out_rem_a (r1_p),
		.out_rem_b (r1_q),
		.out_pay   (pay1_out)
	);

	// Stage 2: truncated remainder for encode, non-negative residue for decode.
	logic p1_func, p1_neg_a, p1_neg_b;
	logic signed [MW:0] res_p, res_q;
	logic func_s2;
	logic [RW-1:0] rand_p_s2, rand_q_s2;
	logic signed [MW:0] res_p_s2, res_q_s2;

	assign p1_func  = pay1_out[PW1-1];
	assign p1_neg_a = pay1_out[PW1-2];
	assign p1_neg_b = pay1_out[PW1-3];

	always_comb begin
		if (p1_func == crt_pkg::FUNC_DECODE) begin
			res_p = {1'b0, (p1_neg_a && r1_p != '0) ? MW'(p_q - r1_p) : r1_p};
			res_q = {1'b0, (p1_neg_b && r1_q != '0) ? MW'(q_q - r1_q) : r1_q};
		end else begin
			res_p = (p_q == '0) ? '0 : (p1_neg_a ? -$signed({1'b0, r1_p}) : {1'b0, r1_p});
			res_q = (q_q == '0) ? '0 : (p1_neg_b ? -$signed({1'b0, r1_q}) : {1'b0, r1_q});
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			func_s2   <= p1_func;
			rand_p_s2 <= pay1_out[2*RW-1:RW];
			rand_q_s2 <= pay1_out[RW-1:0];
			res_p_s2  <= res_p;
			res_q_s2  <= res_q;
		end
	end

	// Stage 3: one multiplier per lane, mask product or coefficient product.
	logic signed [MW:0]    op_a_p, op_b_p, op_a_q, op_b_q;
	logic                  func_s3;
	logic signed [DW2-1:0] prod_p_s3, prod_q_s3;
	logic signed [MW:0]    trem_p_s3, trem_q_s3;

	always_comb begin
		if (func_s2 == crt_pkg::FUNC_DECODE) begin
			op_a_p = res_p_s2;
			op_b_p = cx_q;
			op_a_q = res_q_s2;
			op_b_q = cy_q;
		end else begin
			op_a_p = $signed({1'b0, p_q});
			op_b_p = $signed({(MW+1-RW)'(0), rand_p_s2});
			op_a_q = $signed({1'b0, q_q});
			op_b_q = $signed({(MW+1-RW)'(0), rand_q_s2});
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			func_s3   <= func_s2;
			prod_p_s3 <= DW2'(op_a_p * op_b_p);
			prod_q_s3 <= DW2'(op_a_q * op_b_q);
			trem_p_s3 <= res_p_s2;
			trem_q_s3 <= res_q_s2;
		end
	end

	// Stage 4: encode sums, decode product magnitudes.
	logic          func_s4, neg_p_s4, neg_q_s4;
	logic [XW-1:0] ex_s4, ey_s4;
	logic [DW2-1:0] mag_p_s4, mag_q_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			func_s4  <= func_s3;
			ex_s4    <= XW'(prod_p_s3 + DW2'(trem_p_s3));
			ey_s4    <= XW'(prod_q_s3 + DW2'(trem_q_s3));
			neg_p_s4 <= prod_p_s3[DW2-1];
			neg_q_s4 <= prod_q_s3[DW2-1];
			mag_p_s4 <= prod_p_s3[DW2-1] ? DW2'(-prod_p_s3) : DW2'(prod_p_s3);
			mag_q_s4 <= prod_q_s3[DW2-1] ? DW2'(-prod_q_s3) : DW2'(prod_q_s3);
		end
	end

	logic [MW-1:0]  r2_p, r2_q;
	logic [PW2-1:0] pay2_out;

	crt_rem_pipe #(.MW(MW), .DW(DW2), .PW(PW2)) u_rem_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v4_s4),
		.in_ready  (p2_in_ready),
		.in_dvd_a  (mag_p_s4),
		.in_dvd_b  (mag_q_s4),
		.div_a     (p_q),
		.div_b     (q_q),
		.in_pay    ({func_s4, neg_p_s4, neg_q_s4, ex_s4, ey_s4}),
		.out_valid (p2_out_valid),
		.out_ready (en5),
		.out_rem_a (r2_p),
		.out_rem_b (r2_q),
		.out_pay   (pay2_out)
	);

	// Stage 5: residues a = x*cx mod p and b = y*cy mod q; the encode sums pass through.
	logic          p2_neg_a, p2_neg_b;
	logic          func_s5;
	logic [XW-1:0] ex_s5, ey_s5;
	logic [MW-1:0] a_s5, b_s5;

	assign p2_neg_a = pay2_out[PW2-2];
	assign p2_neg_b = pay2_out[PW2-3];

	always_ff @(posedge clk) begin
		if (en5) begin
			func_s5 <= pay2_out[PW2-1];
			ex_s5   <= pay2_out[2*XW-1:XW];
			ey_s5   <= pay2_out[XW-1:0];
			a_s5    <= (p2_neg_a && r2_p != '0) ? MW'(p_q - r2_p) : r2_p;
			b_s5    <= (p2_neg_b && r2_q != '0) ? MW'(q_q - r2_q) : r2_q;
		end
	end

	// Stages 6 to 9: q*a + p*b, reduce below M, fold to the signed range.
	logic            func_s6, func_s7, func_s8, func_s9;
	logic [XW-1:0]   ex_s6, ey_s6, ex_s7, ey_s7, ex_s8, ey_s8, ex_s9, ey_s9;
	logic [2*MW-1:0] ta_s6, tb_s6;
	logic [2*MW:0]   sum_s7;
	logic [2*MW-1:0] red_s8;
	logic signed [2*MW:0] fold;
	logic [crt_pkg::DEC_W-1:0] dec_s9;

	always_comb begin
		if (m_q == '0) begin
			fold = '0;
		end else if (red_s8 >= (m_q >> 1)) begin
			fold = $signed({1'b0, red_s8}) - $signed({1'b0, m_q});
		end else begin
			fold = $signed({1'b0, red_s8});
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			func_s6 <= func_s5;
			ex_s6   <= ex_s5;
			ey_s6   <= ey_s5;
			ta_s6   <= q_q * a_s5;
			tb_s6   <= p_q * b_s5;
		end
		if (en7) begin
			func_s7 <= func_s6;
			ex_s7   <= ex_s6;
			ey_s7   <= ey_s6;
			sum_s7  <= {1'b0, ta_s6} + {1'b0, tb_s6};
		end
		if (en8) begin
			func_s8 <= func_s7;
			ex_s8   <= ex_s7;
			ey_s8   <= ey_s7;
			red_s8  <= (sum_s7 >= {1'b0, m_q}) ? (2*MW)'(sum_s7 - {1'b0, m_q})
				: (2*MW)'(sum_s7);
		end
		if (en9) begin
			func_s9 <= func_s8;
			ex_s9   <= (func_s8 == crt_pkg::FUNC_DECODE) ? '0 : ex_s8;
			ey_s9   <= (func_s8 == crt_pkg::FUNC_DECODE) ? '0 : ey_s8;
			dec_s9  <= (func_s8 == crt_pkg::FUNC_DECODE) ? crt_pkg::DEC_W'(fold) : '0;
		end
	end

	assign m_axis_tvalid = v9_s9;
	assign m_axis_tdata  = {2'b00, dec_s9, ey_s9, ex_s9};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready with an empty output stage");

	a_operand_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		p1_out_valid && p_q != '0 |-> r1_p < p_q)
		else $error("operand remainder not below p");

	a_residue_range: assert property (@(posedge clk) disable iff (!arst_n)
		v6_s6 && func_s6 == crt_pkg::FUNC_DECODE && m_q != '0 |-> ta_s6 < m_q)
		else $error("q*a term not below M");

	a_reduced_range: assert property (@(posedge clk) disable iff (!arst_n)
		v8_s8 && func_s8 == crt_pkg::FUNC_DECODE && m_q != '0 |-> red_s8 < m_q)
		else $error("reduced sum not below M");

	a_encode_no_decode: assert property (@(posedge clk) disable iff (!arst_n)
		v9_s9 && func_s9 == crt_pkg::FUNC_ENCODE |-> dec_s9 == '0)
		else $error("decoded value set on an encode beat");

endmodule

FILE: tb/sv/crt_codec_checker.sv
// Checker for the two-residue CRT codec: watches the input, output and configuration
// channels, predicts every output beat and compares it field by field.
// Depends on crt_pkg.
module crt_codec_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [crt_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic [0:0]                        s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [crt_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [crt_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [crt_pkg::MODULUS_WIDTH:0]   cfg_data,
	output int                                fail_count,
	output int                                pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic signed [crt_pkg::OUT_XY_W-1:0] out_x;
		logic signed [crt_pkg::OUT_XY_W-1:0] out_y;
		logic signed [crt_pkg::DEC_W-1:0]    decoded;
	} codec_result_t;

	logic [crt_pkg::MODULUS_WIDTH-1:0]      mod_p;
	logic [crt_pkg::MODULUS_WIDTH-1:0]      mod_q;
	logic signed [crt_pkg::MODULUS_WIDTH:0] coef_x;
	logic signed [crt_pkg::MODULUS_WIDTH:0] coef_y;
	codec_result_t                          expected_q[$];

	function automatic wide_t mod_pos(input wide_t a, input wide_t m);
		wide_t r;
		r = a % m;
		if (r < 0)
			r = r + m;
		return r;
	endfunction

	function automatic codec_result_t crt_predict(input crt_pkg::func_t f,
		input logic [crt_pkg::IN_TDATA_W-1:0] d);
		codec_result_t res;
		wide_t p, q, m, v, rp, rq, rem_p, rem_q, ex, ey, cx, cy, tx, ty, s;
		res = '0;
		p = {{(128-crt_pkg::MODULUS_WIDTH){1'b0}}, mod_p};
		q = {{(128-crt_pkg::MODULUS_WIDTH){1'b0}}, mod_q};
		v = $signed(d[31:0]);
		rp = {120'd0, d[39:32]};
		rq = {120'd0, d[47:40]};
		ex = $signed(d[111:48]);
		ey = $signed(d[175:112]);
		cx = coef_x;
		cy = coef_y;
		if (f == crt_pkg::FUNC_ENCODE) begin
			rem_p = (p == 0) ? 0 : v % p;
			rem_q = (q == 0) ? 0 : v % q;
			res.out_x = crt_pkg::OUT_XY_W'(p * rp + rem_p);
			res.out_y = crt_pkg::OUT_XY_W'(q * rq + rem_q);
		end else begin
			m = p * q;
			if (m != 0) begin
				tx = mod_pos(mod_pos(mod_pos(ex, m) * mod_pos(cx, m), m) * q, m);
				ty = mod_pos(mod_pos(mod_pos(ey, m) * mod_pos(cy, m), m) * p, m);
				s = (tx + ty) % m;
				if (s >= m / 2)
					s = s - m;
				res.decoded = crt_pkg::DEC_W'(s);
			end
		end
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		codec_result_t got, want;
		int errs;
		if (!arst_n) begin
			mod_p <= crt_pkg::MODULUS_WIDTH'(crt_pkg::P_RESET);
			mod_q <= crt_pkg::MODULUS_WIDTH'(crt_pkg::Q_RESET);
			coef_x <= (crt_pkg::MODULUS_WIDTH+1)'(crt_pkg::CX_RESET);
			coef_y <= (crt_pkg::MODULUS_WIDTH+1)'(crt_pkg::CY_RESET);
			fail_count <= 0;
			expected_q.delete();
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (crt_pkg::cfg_index_t'(cfg_index))
					crt_pkg::CFG_MODULUS_P:  mod_p <= cfg_data[crt_pkg::MODULUS_WIDTH-1:0];
					crt_pkg::CFG_MODULUS_Q:  mod_q <= cfg_data[crt_pkg::MODULUS_WIDTH-1:0];
					crt_pkg::CFG_COEF_FOR_X: coef_x <= cfg_data;
					crt_pkg::CFG_COEF_FOR_Y: coef_y <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(crt_predict(crt_pkg::func_t'(s_tuser[0]), s_tdata));
			if (m_tvalid && m_tready) begin
				got.out_x = m_tdata[25:0];
				got.out_y = m_tdata[51:26];
				got.decoded = m_tdata[85:52];
				if (expected_q.size() == 0) begin
					$error("output beat with nothing expected: %h", m_tdata);
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (got.out_x !== want.out_x) begin
						$error("out_x expected %0d actual %0d", want.out_x, got.out_x);
						errs++;
					end
					if (got.out_y !== want.out_y) begin
						$error("out_y expected %0d actual %0d", want.out_y, got.out_y);
						errs++;
					end
					if (got.decoded !== want.decoded) begin
						$error("decoded_value expected %0d actual %0d",
							want.decoded, got.decoded);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

FILE: tb/sv/tb_two_residue_crt_codec_top.sv
// Testbench top for the two-residue CRT codec: clock, reset, directed and random
// stimulus over several register settings, receiver stalls and the verdict.
// Depends on crt_pkg, crt_codec_checker and two_residue_crt_codec_top.
module tb_two_residue_crt_codec_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT = 200;

	logic                                clk;
	logic                                arst_n;
	logic                                s_axis_tvalid;
	logic                                s_axis_tready;
	logic [crt_pkg::IN_TDATA_W-1:0]      s_axis_tdata;
	logic [0:0]                          s_axis_tuser;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready;
	logic [crt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [crt_pkg::CFG_INDEX_W-1:0]     cfg_index;
	logic [crt_pkg::MODULUS_WIDTH:0]     cfg_data;
	int                                  fail_count;
	int                                  pending;
	int                                  cycles;
	int                                  burst_left;

	two_residue_crt_codec_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	crt_codec_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
		.m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_residue_crt_codec_top verification failed");
			$finish;
		end
	end

	// Receiver: random stall patterns, plus one long hold-off so the pipeline backs up.
	initial begin
		int mode, run, hold;
		bit held;
		m_axis_tready <= 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			run = $urandom_range(5, 60);
			if (!held && pending > 40) begin
				held = 1'b1;
				hold = 400;
				repeat (hold) begin
					m_axis_tready <= 1'b0;
					@(posedge clk);
				end
			end
			repeat (run) begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic send_beat(input crt_pkg::func_t f, input logic signed [31:0] pv,
		input logic [7:0] rp, input logic [7:0] rq,
		input logic signed [63:0] ex, input logic signed [63:0] ey);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= f;
		s_axis_tdata <= {ey, ex, rq, rp, pv};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input crt_pkg::cfg_index_t idx,
		input logic [crt_pkg::MODULUS_WIDTH:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_regs(input int p, input int q, input int cx, input int cy);
		drain();
		write_reg(crt_pkg::CFG_MODULUS_P, (crt_pkg::MODULUS_WIDTH+1)'(p));
		write_reg(crt_pkg::CFG_MODULUS_Q, (crt_pkg::MODULUS_WIDTH+1)'(q));
		write_reg(crt_pkg::CFG_COEF_FOR_X, (crt_pkg::MODULUS_WIDTH+1)'(cx));
		write_reg(crt_pkg::CFG_COEF_FOR_Y, (crt_pkg::MODULUS_WIDTH+1)'(cy));
	endtask

	task automatic random_beats(input int count);
		logic signed [63:0] ex, ey;
		logic signed [31:0] pv;
		repeat (count) begin
			ex = {$urandom, $urandom};
			ey = {$urandom, $urandom};
			pv = $urandom;
			case ($urandom_range(0, 3))
				0: begin
					ex = $signed(ex) >>> $urandom_range(0, 63);
					ey = $signed(ey) >>> $urandom_range(0, 63);
					pv = $signed(pv) >>> $urandom_range(0, 31);
				end
				1: begin
					ex = 64'($signed($urandom_range(0, 1000)) - 500);
					ey = 64'($signed($urandom_range(0, 1000)) - 500);
				end
				default: ;
			endcase
			send_beat(crt_pkg::func_t'($urandom_range(0, 1)), pv,
				($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 99))),
				($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 99))),
				ex, ey);
		end
	endtask

	task automatic directed_beats();
		send_beat(crt_pkg::FUNC_ENCODE, 32'sh7fffffff, 8'd255, 8'd255, 64'sd0, 64'sd0);
		send_beat(crt_pkg::FUNC_ENCODE, 32'sh80000000, 8'd0, 8'd0, -64'sd1, -64'sd1);
		send_beat(crt_pkg::FUNC_ENCODE, 32'sd0, 8'd0, 8'd255, 64'sd0, 64'sd0);
		send_beat(crt_pkg::FUNC_ENCODE, -32'sd1, 8'd99, 8'd1, 64'sd0, 64'sd0);
		send_beat(crt_pkg::FUNC_ENCODE, 32'sd104729, 8'd7, 8'd3, 64'sd0, 64'sd0);
		send_beat(crt_pkg::FUNC_DECODE, 32'sd0, 8'd0, 8'd0, 64'sd0, 64'sd0);
		send_beat(crt_pkg::FUNC_DECODE, -32'sd1, 8'd255, 8'd255,
			64'sh7fffffffffffffff, 64'sh8000000000000000);
		send_beat(crt_pkg::FUNC_DECODE, 32'sd0, 8'd0, 8'd0,
			64'sh8000000000000000, 64'sh7fffffffffffffff);
		send_beat(crt_pkg::FUNC_DECODE, 32'sd0, 8'd0, 8'd0, -64'sd1, -64'sd1);
		send_beat(crt_pkg::FUNC_DECODE, 32'sd0, 8'd0, 8'd0, 64'sd1, 64'sd0);
		send_beat(crt_pkg::FUNC_DECODE, 32'sd0, 8'd0, 8'd0, 64'sd0, 64'sd1);
		send_beat(crt_pkg::FUNC_DECODE, 32'sd0, 8'd0, 8'd0, 64'sd104728, 64'sd104622);
	endtask

	initial begin
		arst_n = 1'b0;
		cycles = 0;
		burst_left = 4;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= crt_pkg::CFG_MODULUS_P;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_beats();
		random_beats(200);

		set_regs(3, 5, 2, 2);
		directed_beats();
		random_beats(60);

		set_regs(131071, 131069, -131071, 131071);
		random_beats(70);

		set_regs(2, 2, -1, 1);
		random_beats(40);

		set_regs(2, 131071, 131071, -131071);
		random_beats(40);

		set_regs($urandom_range(2, 131071), $urandom_range(2, 131071),
			$urandom_range(0, 262142) - 131071, $urandom_range(0, 262142) - 131071);
		random_beats(60);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("two_residue_crt_codec_top verification clean");
		else
			$display("two_residue_crt_codec_top verification failed");
		$finish;
	end

endmodule

FILE: files.f
src/crt_pkg.sv
src/crt_rem_pipe.sv
src/two_residue_crt_codec_top.sv
tb/sv/crt_codec_checker.sv
tb/sv/tb_two_residue_crt_codec_top.sv
